// File: rtl/lpm_pkg.sv
// Shared types and constants for the longest-prefix-match lookup block.
`timescale 1ns / 1ps

package lpm_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_PORT_COUNT  = 4;

    // Fixed field widths
    localparam int ADDR_W = 32;
    localparam int SLOT_W = 4;
    localparam int PORT_W = 2;

    // Transaction command codes
    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } lpm_cmd_t;

    // Input transaction
    typedef struct packed {
        lpm_cmd_t          cmd;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] entry_prefix;
        logic [ADDR_W-1:0] entry_netmask;
        logic [PORT_W-1:0] entry_port;
        logic              entry_enable;
        logic [ADDR_W-1:0] lookup_addr;
    } lpm_in_t;

    // Result transaction
    typedef struct packed {
        logic              hit;
        logic [PORT_W-1:0] out_port;
        logic [SLOT_W-1:0] match_slot;
        logic [ADDR_W-1:0] match_netmask;
    } lpm_out_t;

    // One match candidate; all fields are zero when found is low
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] mask;
        logic [PORT_W-1:0] port;
        logic [SLOT_W-1:0] slot;
    } lpm_cand_t;

endpackage

// File: rtl/lpm_table.sv
// Route table storage, slot writes and per-entry match compare.
`timescale 1ns / 1ps

module lpm_table #(
    parameter int TABLE_DEPTH = lpm_pkg::DEF_TABLE_DEPTH,
    parameter int PORT_COUNT  = lpm_pkg::DEF_PORT_COUNT,
    parameter int LEAVES      = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             valid_in,
    input  lpm_pkg::lpm_in_t                 data_in,
    output logic                             valid_out,
    output lpm_pkg::lpm_cand_t [LEAVES-1:0]  cand_out
);
    import lpm_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [ADDR_W-1:0] route_prefix  [TABLE_DEPTH];
    logic [ADDR_W-1:0] route_netmask [TABLE_DEPTH];
    logic [PORT_W-1:0] route_port    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] route_valid_reg;

    logic              wr_en;
    logic              wr_load;
    logic [IDX_W-1:0]  wr_idx;
    logic              is_lookup;

    lpm_cand_t [LEAVES-1:0] leaf_next;
    lpm_cand_t [LEAVES-1:0] leaf_reg;
    logic                   valid_reg;

    // Decode the write transaction held in this stage
    always_comb
    begin
        is_lookup = (data_in.cmd == CMD_LOOKUP);
        wr_en     = advance && valid_in && !is_lookup
                    && (32'(data_in.slot) < TABLE_DEPTH);
        wr_load   = data_in.entry_enable && (32'(data_in.entry_port) < PORT_COUNT);
        wr_idx    = IDX_W'(data_in.slot);
    end

    // Load entry payload
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_load)
        begin
            route_prefix[wr_idx]  <= data_in.entry_prefix;
            route_netmask[wr_idx] <= data_in.entry_netmask;
            route_port[wr_idx]    <= data_in.entry_port;
        end
    end

    // Set or drop the valid bit of the written slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            route_valid_reg[wr_idx] <= wr_load;
        end
    end

    // Compare the lookup address against every entry
    always_comb
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            leaf_next[i] = '0;
            if (i < TABLE_DEPTH)
            begin
                if (is_lookup && route_valid_reg[i]
                    && (((data_in.lookup_addr ^ route_prefix[i]) & route_netmask[i]) == '0))
                begin
                    leaf_next[i].found = 1'b1;
                    leaf_next[i].mask  = route_netmask[i];
                    leaf_next[i].port  = route_port[i];
                    leaf_next[i].slot  = SLOT_W'(i);
                end
            end
        end
    end

    // Advance the candidate stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in && is_lookup;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            leaf_reg <= leaf_next;
        end
    end

    assign valid_out = valid_reg;
    assign cand_out  = leaf_reg;

endmodule

// File: rtl/lpm_merge.sv
// One registered level of the best-match reduction tree.
`timescale 1ns / 1ps

module lpm_merge #(
    parameter int N_IN = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              valid_in,
    input  lpm_pkg::lpm_cand_t [N_IN-1:0]     cand_in,
    output logic                              valid_out,
    output lpm_pkg::lpm_cand_t [N_IN/2-1:0]   cand_out
);
    import lpm_pkg::*;

    localparam int N_OUT = N_IN / 2;

    lpm_cand_t [N_OUT-1:0] node_next;
    lpm_cand_t [N_OUT-1:0] node_reg;
    logic                  valid_reg;

    // Pick the greater mask; the lower slot wins a tie
    always_comb
    begin
        for (int i = 0; i < N_OUT; i++)
        begin
            if (cand_in[2*i].found
                && (!cand_in[2*i+1].found || (cand_in[2*i].mask >= cand_in[2*i+1].mask)))
            begin
                node_next[i] = cand_in[2*i];
            end
            else
            begin
                node_next[i] = cand_in[2*i+1];
            end
        end
    end

    // Advance the level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            node_reg <= node_next;
        end
    end

    assign valid_out = valid_reg;
    assign cand_out  = node_reg;

endmodule

// File: rtl/longest_prefix_match_lookup.sv
// Top level of the IPv4 longest-prefix-match lookup pipeline.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// output register waits on out_ready.
// Writes take effect in the compare stage, so lookups see all earlier writes.
// Reset clears every route valid bit and all pipeline valid bits.
`timescale 1ns / 1ps

module longest_prefix_match_lookup #(
    parameter int TABLE_DEPTH = lpm_pkg::DEF_TABLE_DEPTH,
    parameter int PORT_COUNT  = lpm_pkg::DEF_PORT_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lpm_pkg::lpm_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lpm_pkg::lpm_out_t out_data
);
    import lpm_pkg::*;

    localparam int LEVELS = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LEAVES = 1 << LEVELS;

    logic                                advance;
    logic                                s1_valid_reg;
    lpm_in_t                             s1_data_reg;
    logic      [LEVELS:0]                vld;
    lpm_cand_t [LEVELS:0][LEAVES-1:0]    lvl;
    lpm_cand_t                           root;

    // Move every stage together unless the result is held
    assign advance  = !vld[LEVELS] || out_ready;
    assign in_ready = advance;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            s1_data_reg <= in_data;
        end
    end

    // Table writes and per-entry compare
    lpm_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PORT_COUNT  (PORT_COUNT),
        .LEAVES      (LEAVES)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (s1_valid_reg),
        .data_in   (s1_data_reg),
        .valid_out (vld[0]),
        .cand_out  (lvl[0])
    );

    // Reduction tree, one register level per stage
    for (genvar k = 0; k < LEVELS; k++)
    begin : g_level
        lpm_merge #(
            .N_IN (LEAVES >> k)
        ) u_merge (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (vld[k]),
            .cand_in   (lvl[k][(LEAVES >> k)-1:0]),
            .valid_out (vld[k+1]),
            .cand_out  (lvl[k+1][(LEAVES >> (k+1))-1:0])
        );

        for (genvar j = (LEAVES >> (k+1)); j < LEAVES; j++)
        begin : g_tie
            assign lvl[k+1][j] = '0;
        end
    end

    // Drive the result; a miss leaves every field zero
    assign root                   = lvl[LEVELS][0];
    assign out_valid              = vld[LEVELS];
    assign out_data.hit           = root.found;
    assign out_data.out_port      = root.port;
    assign out_data.match_slot    = root.slot;
    assign out_data.match_netmask = root.mask;

endmodule
